// ===== src/gace_pkg.sv =====
`default_nettype none
package gace_pkg;

    localparam int NODES      = 32;
    localparam int IDX_W      = 5;
    localparam int ROW_W      = NODES;
    localparam int CNT_W      = 6;
    localparam int DEG_W      = 5;
    localparam int TRI_W      = 9;
    localparam int DEN_W      = 10;
    localparam int REM_W      = DEN_W;
    localparam int COEF_W     = 16;
    localparam int FRAC_W     = 16;
    localparam int DIVD_W     = TRI_W + FRAC_W;
    localparam int DIV_STEPS  = DIVD_W;
    localparam int ACT_W      = 2;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 40;
    localparam int M_FIELDS_W = CNT_W + DEG_W + TRI_W + COEF_W;

    localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(32768);

    typedef enum logic [ACT_W-1:0] {
        ACT_CLEAR    = 2'd0,
        ACT_ADD_EDGE = 2'd1,
        ACT_COMMON   = 2'd2,
        ACT_CLUSTER  = 2'd3
    } act_t;

    typedef enum logic [1:0] {
        SEL_A,
        SEL_B,
        SEL_CNT
    } rd_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_CLEAR,
        ST_EA_WR,
        ST_EB_WR,
        ST_CN_RB,
        ST_CN_CALC,
        ST_CC_ROW,
        ST_CC_WALK,
        ST_CC_MUL,
        ST_CC_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic    capture;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    clear_all;
        logic    wr_a_edge;
        logic    wr_b_edge;
        logic    latch_row_a;
        logic    calc_common;
        logic    cc_init;
        logic    cc_walk;
        logic    div_init;
        logic    div_step;
        logic    load_out;
    } dp_cmd_t;

    typedef struct packed {
        act_t act;
        logic same_ab;
        logic deg_lt2;
        logic walk_last;
        logic div_last;
        logic out_busy;
    } dp_status_t;

    function automatic logic [CNT_W-1:0] popcount(input logic [ROW_W-1:0] v);
        logic [CNT_W-1:0] c;
        c = '0;
        for (int i = 0; i < ROW_W; i++) begin
            c = c + CNT_W'(v[i]);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== src/gace_ctrl.sv =====
`default_nettype none
module gace_ctrl
    import gace_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_DISPATCH;
            end
            ST_DISPATCH: begin
                unique case (status.act)
                    ACT_CLEAR:    state_next = ST_CLEAR;
                    ACT_ADD_EDGE: state_next = ST_EA_WR;
                    ACT_COMMON:   state_next = ST_CN_RB;
                    ACT_CLUSTER:  state_next = ST_CC_ROW;
                    default:      state_next = ST_DONE;
                endcase
            end
            ST_CLEAR:   state_next = ST_DONE;
            ST_EA_WR:   state_next = status.same_ab ? ST_DONE : ST_EB_WR;
            ST_EB_WR:   state_next = ST_DONE;
            ST_CN_RB:   state_next = ST_CN_CALC;
            ST_CN_CALC: state_next = ST_DONE;
            ST_CC_ROW:  state_next = ST_CC_WALK;
            ST_CC_WALK: begin
                if (status.walk_last) state_next = ST_CC_MUL;
            end
            ST_CC_MUL:  state_next = status.deg_lt2 ? ST_DONE : ST_CC_DIV;
            ST_CC_DIV: begin
                if (status.div_last) state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!status.out_busy) state_next = ST_IDLE;
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        cmd.rd_sel = SEL_A;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            ST_DISPATCH: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = SEL_A;
            end
            ST_CLEAR: cmd.clear_all = 1'b1;
            ST_EA_WR: begin
                // write row a while row b is fetched
                cmd.wr_a_edge = 1'b1;
                cmd.rd_en     = 1'b1;
                cmd.rd_sel    = SEL_B;
            end
            ST_EB_WR: cmd.wr_b_edge = 1'b1;
            ST_CN_RB: begin
                cmd.latch_row_a = 1'b1;
                cmd.rd_en       = 1'b1;
                cmd.rd_sel      = SEL_B;
            end
            ST_CN_CALC: cmd.calc_common = 1'b1;
            ST_CC_ROW: begin
                cmd.cc_init = 1'b1;
                cmd.rd_en   = 1'b1;
                cmd.rd_sel  = SEL_CNT;
            end
            ST_CC_WALK: begin
                cmd.cc_walk = 1'b1;
                cmd.rd_en   = 1'b1;
                cmd.rd_sel  = SEL_CNT;
            end
            ST_CC_MUL: cmd.div_init = 1'b1;
            ST_CC_DIV: cmd.div_step = 1'b1;
            ST_DONE:   cmd.load_out = !status.out_busy;
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== src/gace_dp.sv =====
`default_nettype none
module gace_dp
    import gace_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic                 m_tready,
    input  wire dp_cmd_t              cmd,
    output dp_status_t                status,
    output logic                      m_tvalid,
    output logic [M_TDATA_W-1:0]      m_tdata,
    output logic                      m_tuser
);

    logic [ROW_W-1:0] mem [NODES];

    act_t              act_reg, act_next;
    logic [IDX_W-1:0]  a_reg, a_next;
    logic [IDX_W-1:0]  b_reg, b_next;
    logic [NODES-1:0]  valid_reg, valid_next;
    logic [ROW_W-1:0]  rd_data_reg;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [CNT_W-1:0]  common_reg, common_next;
    logic [DEG_W-1:0]  deg_reg, deg_next;
    logic [TRI_W-1:0]  tri_reg, tri_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DEN_W-1:0]  den_reg, den_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [DIVD_W-1:0] quo_reg, quo_next;
    logic              out_valid_reg, out_valid_next;
    logic [M_FIELDS_W-1:0] out_data_reg, out_data_next;
    logic              out_flag_reg, out_flag_next;

    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [ROW_W-1:0]  wr_data;
    logic [ROW_W-1:0]  bit_a, bit_b;
    logic [ROW_W-1:0]  above;
    logic [ROW_W-1:0]  own_row;
    logic [CNT_W-1:0]  own_pc;
    logic [CNT_W-1:0]  walk_pc;
    logic [REM_W:0]    rem_sh;
    logic [REM_W:0]    rem_sub;
    logic              deg_lt2;
    logic [COEF_W-1:0] coef_sat;
    logic [CNT_W-1:0]  common_f;
    logic [DEG_W-1:0]  deg_f;
    logic [TRI_W-1:0]  tri_f;
    logic [COEF_W-1:0] coef_f;
    logic              flag_f;

    assign bit_a   = ROW_W'(1) << a_reg;
    assign bit_b   = ROW_W'(1) << b_reg;
    assign deg_lt2 = deg_reg < DEG_W'(2);

    always_comb begin
        unique case (cmd.rd_sel)
            SEL_A:   rd_addr = a_reg;
            SEL_B:   rd_addr = b_reg;
            SEL_CNT: rd_addr = cnt_next[IDX_W-1:0];
            default: rd_addr = a_reg;
        endcase
    end

    always_comb begin
        wr_en   = cmd.wr_a_edge || cmd.wr_b_edge;
        wr_addr = cmd.wr_b_edge ? b_reg : a_reg;
        if (cmd.wr_b_edge) begin
            wr_data = rd_data_reg | bit_a;
        end else if (a_reg == b_reg) begin
            wr_data = rd_data_reg & ~bit_a;
        end else begin
            wr_data = rd_data_reg | bit_b;
        end
    end

    // rows never written since reset or clear read as zero
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= valid_reg[rd_addr] ? mem[rd_addr] : '0;
        end
    end

    always_comb begin
        for (int k = 0; k < ROW_W; k++) begin
            above[k] = CNT_W'(k) > cnt_reg;
        end
    end

    assign own_row = rd_data_reg & ~bit_a;
    assign own_pc  = popcount(own_row);
    assign walk_pc = popcount(row_reg & rd_data_reg & above);
    assign rem_sh  = {rem_reg, quo_reg[DIVD_W-1]};
    assign rem_sub = rem_sh - {1'b0, den_reg};
    assign coef_sat = (quo_reg > DIVD_W'(COEF_ONE)) ? COEF_ONE : quo_reg[COEF_W-1:0];

    always_comb begin
        common_f = '0;
        deg_f    = '0;
        tri_f    = '0;
        coef_f   = '0;
        flag_f   = 1'b0;
        unique case (act_reg)
            ACT_COMMON: common_f = common_reg;
            ACT_CLUSTER: begin
                deg_f  = deg_reg;
                tri_f  = tri_reg;
                coef_f = deg_lt2 ? '0 : coef_sat;
                flag_f = deg_lt2;
            end
            default: begin
                flag_f = 1'b0;
            end
        endcase
    end

    always_comb begin
        act_next       = act_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        valid_next     = valid_reg;
        row_next       = row_reg;
        common_next    = common_reg;
        deg_next       = deg_reg;
        tri_next       = tri_reg;
        cnt_next       = cnt_reg;
        den_next       = den_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        out_data_next  = out_data_reg;
        out_flag_next  = out_flag_reg;
        out_valid_next = out_valid_reg && !m_tready;

        if (cmd.capture) begin
            act_next = act_t'(s_tdata[ACT_W-1:0]);
            a_next   = s_tdata[ACT_W +: IDX_W];
            b_next   = s_tdata[ACT_W+IDX_W +: IDX_W];
        end
        if (cmd.clear_all) begin
            valid_next = '0;
        end
        if (wr_en) begin
            valid_next[wr_addr] = 1'b1;
        end
        if (cmd.latch_row_a) begin
            row_next = rd_data_reg;
        end
        if (cmd.calc_common) begin
            common_next = (a_reg == b_reg) ? '0 : popcount(row_reg & rd_data_reg);
        end
        if (cmd.cc_init) begin
            row_next = own_row;
            deg_next = own_pc[DEG_W-1:0];
            tri_next = '0;
            cnt_next = '0;
        end
        if (cmd.cc_walk) begin
            // rd_data_reg holds the row of node cnt_reg
            if (row_reg[cnt_reg[IDX_W-1:0]]) begin
                tri_next = tri_reg + TRI_W'(walk_pc);
            end
            cnt_next = cnt_reg + CNT_W'(1);
        end
        if (cmd.div_init) begin
            den_next = DEN_W'(deg_reg) * DEN_W'(deg_reg - DEG_W'(1));
            rem_next = '0;
            quo_next = {tri_reg, {FRAC_W{1'b0}}};
            cnt_next = '0;
        end
        if (cmd.div_step) begin
            // restoring division, one quotient bit per cycle
            if (!rem_sub[REM_W]) begin
                rem_next = rem_sub[REM_W-1:0];
                quo_next = {quo_reg[DIVD_W-2:0], 1'b1};
            end else begin
                rem_next = rem_sh[REM_W-1:0];
                quo_next = {quo_reg[DIVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + CNT_W'(1);
        end
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
            out_data_next  = {coef_f, tri_f, deg_f, common_f};
            out_flag_next  = flag_f;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        act_reg      <= act_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        row_reg      <= row_next;
        common_reg   <= common_next;
        deg_reg      <= deg_next;
        tri_reg      <= tri_next;
        cnt_reg      <= cnt_next;
        den_reg      <= den_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        out_data_reg <= out_data_next;
        out_flag_reg <= out_flag_next;
    end

    always_comb begin
        status.act       = act_reg;
        status.same_ab   = a_reg == b_reg;
        status.deg_lt2   = deg_lt2;
        status.walk_last = cnt_reg == CNT_W'(NODES - 1);
        status.div_last  = cnt_reg == CNT_W'(DIV_STEPS - 1);
        status.out_busy  = out_valid_reg && !m_tready;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'(out_data_reg);
    assign m_tuser  = out_flag_reg;

endmodule
`default_nettype wire

// ===== src/graph_adjacency_clustering_engine_top.sv =====
`default_nettype none
// adjacency-matrix clustering engine over 32 nodes
// input stream: one transaction per action (clear, add edge, common
// neighbours, clustering query); every transaction yields exactly one result
// transaction on the output stream, in order
// the clustering query reads row a, then walks all 32 node rows through
// the single read port of the row memory (one row a cycle), then runs a
// 25-step restoring divider for the Q1.15 coefficient
// one transaction is worked on at a time; s_tready is high once the previous
// one has moved into the output register, so a new transaction is taken
// while a result still waits there, in the cycle after that result is loaded
// when m_tready is low the result holds in the output register and the
// engine waits in its final state until that register frees up
// reset clears the controller, the output valid and all row valid bits, so
// the matrix reads as empty at once; no clearing pass is needed
module graph_adjacency_clustering_engine_top
    import gace_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // action[1:0], person_a[6:2], person_b[11:7], zero[15:12]
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // common_count[5:0], degree[10:6], triangle_count[19:11],
    // coefficient[35:20], zero[39:36]
    output logic [M_TDATA_W-1:0]      m_tdata,
    // undefined_flag[0]
    output logic                      m_tuser
);

    dp_cmd_t    cmd;
    dp_status_t status;

    gace_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    gace_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
`default_nettype wire

// ===== sim/graph_adjacency_clustering_engine_top_tb.sv =====
`timescale 1ns / 1ps

module graph_adjacency_clustering_engine_top_tb;
    import gace_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int CALM_TAIL   = 150;
    localparam int SETTLE      = 100;
    localparam int OFS_DEG     = CNT_W;
    localparam int OFS_TRI     = CNT_W + DEG_W;
    localparam int OFS_COEF    = CNT_W + DEG_W + TRI_W;

    typedef struct {
        act_t             act;
        logic [IDX_W-1:0] a;
        logic [IDX_W-1:0] b;
        bit               hold;   // sender waits for every answer before this one
    } graph_op_t;

    typedef struct {
        act_t              act;
        logic [CNT_W-1:0]  common;
        logic [DEG_W-1:0]  degree;
        logic [TRI_W-1:0]  triangles;
        logic [COEF_W-1:0] coef;
        logic              undef;
    } graph_answer_t;

    logic                 aclk;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;

    graph_op_t        op_backlog[$];
    graph_answer_t    pending_answers[$];
    logic [NODES-1:0] adj_rows[NODES];
    graph_op_t        next_op;

    int mismatches;
    int ops_sent[4];
    int answers_seen;
    int top_degree;
    int top_triangles;
    int undef_seen;
    int quiet_cycles;
    int tx_gap;
    int rx_gap;
    int tx_cyc;
    int rx_cyc;
    bit tx_live;
    bit tx_idle_ok = 1'b1;
    bit rx_idle_ok = 1'b1;

    graph_adjacency_clustering_engine_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // apply one accepted action to the shadow matrix and queue its answer
    function automatic void advance_graph(input logic [S_TDATA_W-1:0] word);
        act_t             act;
        int               a;
        int               b;
        int               n;
        int               pairs;
        logic [NODES-1:0] row;
        longint           q;
        graph_answer_t    ans;
        act = act_t'(word[1:0]);
        a = int'(word[6:2]);
        b = int'(word[11:7]);
        ans = '{act: act, common: '0, degree: '0, triangles: '0, coef: '0, undef: 1'b0};
        case (act)
            ACT_CLEAR: begin
                foreach (adj_rows[i]) adj_rows[i] = '0;
            end
            ACT_ADD_EDGE: begin
                if (a == b) begin
                    adj_rows[a][a] = 1'b0;
                end else begin
                    adj_rows[a][b] = 1'b1;
                    adj_rows[b][a] = 1'b1;
                end
            end
            ACT_COMMON: begin
                if (a != b) ans.common = CNT_W'($countones(adj_rows[a] & adj_rows[b]));
            end
            ACT_CLUSTER: begin
                row = adj_rows[a];
                row[a] = 1'b0;
                n = $countones(row);
                pairs = 0;
                for (int j = 0; j < NODES; j++) begin
                    for (int k = j + 1; k < NODES; k++) begin
                        if (row[j] && row[k] && adj_rows[j][k]) pairs++;
                    end
                end
                if (n < 2) begin
                    ans.undef = 1'b1;
                end else begin
                    q = (longint'(pairs) << FRAC_W) / longint'(n * (n - 1));
                    if (q > 32768) q = 32768;
                    ans.coef = COEF_W'(q);
                end
                ans.degree = DEG_W'(n > 31 ? 31 : n);
                ans.triangles = TRI_W'(pairs > 511 ? 511 : pairs);
            end
        endcase
        pending_answers.push_back(ans);
    endfunction

    task automatic log_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("mismatch @%0t: %s got %0d want %0d", $time, what, got, want);
    endtask

    task automatic check_answer();
        graph_answer_t want;
        string         tag;
        if (pending_answers.size() == 0) begin
            log_mismatch("result transaction with nothing expected", 1, 0);
        end else begin
            want = pending_answers.pop_front();
            tag = want.act.name();
            answers_seen++;
            if (want.degree > top_degree) top_degree = want.degree;
            if (want.triangles > top_triangles) top_triangles = want.triangles;
            if (want.undef) undef_seen++;
            if (m_tdata[0 +: CNT_W] != want.common)
                log_mismatch({tag, " common_count"}, m_tdata[0 +: CNT_W], want.common);
            if (m_tdata[OFS_DEG +: DEG_W] != want.degree)
                log_mismatch({tag, " degree"}, m_tdata[OFS_DEG +: DEG_W], want.degree);
            if (m_tdata[OFS_TRI +: TRI_W] != want.triangles)
                log_mismatch({tag, " triangle_count"}, m_tdata[OFS_TRI +: TRI_W],
                             want.triangles);
            if (m_tdata[OFS_COEF +: COEF_W] != want.coef)
                log_mismatch({tag, " coefficient"}, m_tdata[OFS_COEF +: COEF_W], want.coef);
            if (m_tuser != want.undef)
                log_mismatch({tag, " undefined_flag"}, m_tuser, want.undef);
        end
    endtask

    function automatic void queue_op(input act_t act, input int a, input int b,
                                     input bit hold = 1'b0);
        graph_op_t op;
        op.act  = act;
        op.a    = IDX_W'(a);
        op.b    = IDX_W'(b);
        op.hold = hold;
        op_backlog.push_back(op);
    endfunction

    // build a random graph on k shuffled nodes, with queries mixed in
    function automatic void queue_episode(input int k, input int density, input int query_pct,
                                          input bit hold);
        int nodes[NODES];
        int edges[$];
        int j;
        int tmp;
        int u;
        int v;
        for (int i = 0; i < NODES; i++) nodes[i] = i;
        for (int i = NODES - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = nodes[i];
            nodes[i] = nodes[j];
            nodes[j] = tmp;
        end
        for (int x = 0; x < k; x++) begin
            for (int y = x + 1; y < k; y++) begin
                if ($urandom_range(1, 100) <= density) edges.push_back(nodes[x] * NODES + nodes[y]);
            end
        end
        for (int i = edges.size() - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = edges[i];
            edges[i] = edges[j];
            edges[j] = tmp;
        end
        queue_op(ACT_CLEAR, $urandom_range(0, NODES - 1), $urandom_range(0, NODES - 1), hold);
        foreach (edges[i]) begin
            u = edges[i] / NODES;
            v = edges[i] % NODES;
            if ($urandom_range(0, 1)) queue_op(ACT_ADD_EDGE, u, v);
            else queue_op(ACT_ADD_EDGE, v, u);
            if ($urandom_range(1, 100) <= query_pct) begin
                if ($urandom_range(0, 1))
                    queue_op(ACT_CLUSTER, nodes[$urandom_range(0, k - 1)],
                             $urandom_range(0, NODES - 1));
                else
                    queue_op(ACT_COMMON, nodes[$urandom_range(0, k - 1)],
                             nodes[$urandom_range(0, k - 1)]);
            end
            if ($urandom_range(0, 29) == 0) begin
                u = nodes[$urandom_range(0, k - 1)];
                queue_op(ACT_ADD_EDGE, u, u);
            end
            // stray action on any node
            if ($urandom_range(0, 24) == 0)
                queue_op(act_t'($urandom_range(1, 3)), $urandom_range(0, NODES - 1),
                         $urandom_range(0, NODES - 1));
        end
        for (int i = 0; i < k; i++) queue_op(ACT_CLUSTER, nodes[i], $urandom_range(0, NODES - 1));
        repeat (3) queue_op(ACT_COMMON, nodes[$urandom_range(0, k - 1)],
                            nodes[$urandom_range(0, k - 1)]);
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_live = 1'b0;
            tx_gap = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                advance_graph(s_tdata);
                ops_sent[s_tdata[1:0]]++;
                tx_live = 1'b0;
            end
            tx_cyc++;
            if (tx_cyc % 256 == 128) tx_idle_ok = $urandom_range(0, 2) != 0;
            if (!tx_live && op_backlog.size() != 0) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (op_backlog[0].hold && pending_answers.size() != 0) begin
                    tx_gap = 0;
                end else if (tx_idle_ok && op_backlog.size() > CALM_TAIL &&
                             $urandom_range(0, 7) == 0) begin
                    tx_gap = $urandom_range(0, 18);
                end else begin
                    next_op = op_backlog.pop_front();
                    s_tdata <= S_TDATA_W'({next_op.b, next_op.a, next_op.act});
                    tx_live = 1'b1;
                end
            end
            s_tvalid <= tx_live;
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_gap = 0;
        end else begin
            if (m_tvalid && m_tready) check_answer();
            rx_cyc++;
            if (rx_cyc % 256 == 0) rx_idle_ok = $urandom_range(0, 2) != 0;
            if (rx_gap > 0) begin
                rx_gap--;
                m_tready <= 1'b0;
            end else if (rx_idle_ok && op_backlog.size() > CALM_TAIL &&
                         $urandom_range(0, 9) == 0) begin
                rx_gap = $urandom_range(0, 18);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            quiet_cycles <= 0;
        end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        graph_answer_t left;
        int            target;
        foreach (adj_rows[i]) adj_rows[i] = '0;

        // hand-picked cases on an empty then tiny graph
        queue_op(ACT_CLUSTER, 0, 31);
        queue_op(ACT_COMMON, 0, 31);
        queue_op(ACT_ADD_EDGE, 0, 31);
        queue_op(ACT_ADD_EDGE, 31, 0);
        queue_op(ACT_ADD_EDGE, 5, 5);
        queue_op(ACT_ADD_EDGE, 0, 1);
        queue_op(ACT_CLUSTER, 0, 0);
        queue_op(ACT_ADD_EDGE, 1, 31);
        queue_op(ACT_CLUSTER, 0, 0);
        queue_op(ACT_CLUSTER, 31, 0);
        queue_op(ACT_COMMON, 1, 31);
        queue_op(ACT_COMMON, 31, 31);
        queue_op(ACT_CLUSTER, 5, 0);
        queue_op(ACT_ADD_EDGE, 5, 0);
        queue_op(ACT_CLUSTER, 5, 31);
        queue_op(ACT_CLUSTER, 0, 0);
        queue_op(ACT_ADD_EDGE, 0, 0);
        queue_op(ACT_COMMON, 0, 0);
        queue_op(ACT_CLUSTER, 0, 0);
        queue_op(ACT_CLEAR, 31, 31);
        queue_op(ACT_CLUSTER, 0, 0);
        queue_op(ACT_COMMON, 1, 31);

        // random graphs, with one complete graph over all nodes in the middle
        target = op_backlog.size() + 1000;
        repeat (4) queue_episode($urandom_range(3, 10), $urandom_range(20, 100), 25, 1'b0);
        queue_episode(NODES, 100, 12, 1'b1);
        while (op_backlog.size() < target) begin
            if ($urandom_range(0, 3) == 0)
                queue_episode($urandom_range(11, 20), $urandom_range(20, 100), 20,
                              $urandom_range(0, 4) == 0);
            else
                queue_episode($urandom_range(3, 10), $urandom_range(20, 100), 25,
                              $urandom_range(0, 4) == 0);
        end

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        do @(negedge aclk);
        while (op_backlog.size() != 0 || tx_live || pending_answers.size() != 0);
        repeat (SETTLE) @(posedge aclk);

        while (pending_answers.size() != 0) begin
            left = pending_answers.pop_front();
            log_mismatch({"missing result for ", left.act.name()}, 0, 1);
        end

        $display("sent %0d clears, %0d edge adds, %0d common-neighbour and %0d clustering queries",
                 ops_sent[ACT_CLEAR], ops_sent[ACT_ADD_EDGE], ops_sent[ACT_COMMON],
                 ops_sent[ACT_CLUSTER]);
        $display("checked %0d results: peak degree %0d, peak triangles %0d, %0d undefined, %0d bad",
                 answers_seen, top_degree, top_triangles, undef_seen, mismatches);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
